### rtl/core/assert_macros.svh
// Assertion helpers used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion lbl failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion lbl failed");
`else
`define ASSERT_CLKD(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### rtl/core/tpsc_pkg.sv
package tpsc_pkg;

   localparam int COORD_BITS = 24;
   localparam int WORD_BITS  = 2 * COORD_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int MAG_BITS   = COORD_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS + 1;
   localparam int ROOT_BITS  = MAG_BITS + 1;
   localparam int UNIT_SHIFT = 14;
   localparam int QUOT_BITS  = UNIT_SHIFT + 1;
   localparam int NUM_BITS   = MAG_BITS + UNIT_SHIFT + 1;
   localparam int NORM_BITS  = 16;
   localparam int PROD_BITS  = COORD_BITS + NORM_BITS;
   localparam int DOT_BITS   = PROD_BITS + 1;
   localparam int OV_BITS    = DOT_BITS + 1;
   localparam int DIR_BITS   = COORD_BITS + 1;
   localparam int FLIP_BITS  = DIR_BITS + NORM_BITS + 1;
   localparam int DEPTH_BITS = 26;
   localparam int AXES       = 6;
   localparam int VERTS      = 6;
   localparam int NORM_LAT   = 3 + ROOT_BITS + 1 + QUOT_BITS + 1;
   localparam int SAT_LAT    = 7;
   localparam int UNIT_ONE   = 1 << UNIT_SHIFT;

   typedef struct packed {
      logic [WORD_BITS-1:0] tri_a_vert0;
      logic [WORD_BITS-1:0] tri_a_vert1;
      logic [WORD_BITS-1:0] tri_a_vert2;
      logic [WORD_BITS-1:0] tri_b_vert0;
      logic [WORD_BITS-1:0] tri_b_vert1;
      logic [WORD_BITS-1:0] tri_b_vert2;
      logic [WORD_BITS-1:0] body_a_pos;
      logic [WORD_BITS-1:0] body_b_pos;
   } req_type;

   typedef struct packed {
      logic                        intersects;
      logic                        normal_from_a;
      logic [DEPTH_BITS-1:0]       depth;
      logic signed [NORM_BITS-1:0] axis_x;
      logic signed [NORM_BITS-1:0] axis_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } pt_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0] x;
      logic signed [NORM_BITS-1:0] y;
   } normal_type;

   function automatic pt_type unpack_pt(input logic [WORD_BITS-1:0] w);
      pt_type p;
      p.x = w[WORD_BITS-1:COORD_BITS];
      p.y = w[COORD_BITS-1:0];
      return p;
   endfunction

endpackage

### rtl/core/tpsc_sqrt.sv
module tpsc_sqrt import tpsc_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [SQ_BITS-1:0]   rad,
   output logic [ROOT_BITS-1:0] root
);
   localparam int W = SQ_BITS + 1;

   logic [W-1:0] rem_ff [ROOT_BITS-1];
   logic [W-1:0] acc_ff [ROOT_BITS];

   // One result bit per stage, classic restoring square root.
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      logic [W-1:0] rem_prev, acc_prev, bitv, trial, rem_in, acc_in;
      if (k == 0) begin : g_first
         assign rem_prev = W'(rad);
         assign acc_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign acc_prev = acc_ff[k-1];
      end
      assign bitv  = W'(1) << (2 * (ROOT_BITS - 1 - k));
      assign trial = acc_prev + bitv;
      always_comb begin
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            acc_in = (acc_prev >> 1) + bitv;
         end else begin
            rem_in = rem_prev;
            acc_in = acc_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
         end
      end
      if (k < ROOT_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign root = acc_ff[ROOT_BITS-1][ROOT_BITS-1:0];
endmodule

### rtl/core/tpsc_div.sv
module tpsc_div import tpsc_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [ROOT_BITS-1:0] den,
   output logic [QUOT_BITS-1:0] quot
);
   logic [NUM_BITS-1:0]  rem_ff [QUOT_BITS-1];
   logic [ROOT_BITS-1:0] den_ff [QUOT_BITS-1];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS];

   // Restoring division, one quotient bit per stage, MSB first. The
   // quotient never exceeds its width because the dividend is below den << QUOT_BITS.
   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [NUM_BITS-1:0]  rem_prev, dsh, rem_in;
      logic [ROOT_BITS-1:0] den_prev;
      logic [QUOT_BITS-1:0] q_prev, q_in;
      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end
      assign dsh = NUM_BITS'(den_prev) << (QUOT_BITS - 1 - k);
      always_comb begin
         if (rem_prev >= dsh) begin
            rem_in = rem_prev - dsh;
            q_in   = q_prev | (QUOT_BITS'(1) << (QUOT_BITS - 1 - k));
         end else begin
            rem_in = rem_prev;
            q_in   = q_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k] <= q_in;
         end
      end
      if (k < QUOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quot = q_ff[QUOT_BITS-1];
endmodule

### rtl/core/tpsc_normal.sv
module tpsc_normal import tpsc_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  pt_type     p0,
   input  pt_type     p1,
   output normal_type nrm
);
   logic signed [DIFF_BITS-1:0] dx_ff, dy_ff;
   logic [MAG_BITS-1:0]         ux2_ff, uy2_ff, ux3_ff, uy3_ff;
   logic [SQ_BITS-1:0]          sqx_ff, sqy_ff, rad_ff;
   logic                        sx2_ff, sy2_ff, sx3_ff, sy3_ff;
   logic [MAG_BITS-1:0]         uxd_ff [ROOT_BITS];
   logic [MAG_BITS-1:0]         uyd_ff [ROOT_BITS];
   logic [1:0]                  sgd_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0]        len;
   logic [NUM_BITS-1:0]         numx_ff, numy_ff;
   logic [ROOT_BITS-1:0]        den_ff;
   logic [2:0]                  flg4_ff;
   logic [2:0]                  flgd_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0]        qx, qy;
   logic [MAG_BITS-1:0]         ux_in, uy_in;
   normal_type                  nrm_ff, nrm_in;

   always_comb begin
      ux_in = dx_ff[DIFF_BITS-1] ? MAG_BITS'(-dx_ff) : MAG_BITS'(dx_ff);
      uy_in = dy_ff[DIFF_BITS-1] ? MAG_BITS'(-dy_ff) : MAG_BITS'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= DIFF_BITS'(p1.x) - DIFF_BITS'(p0.x);
         dy_ff  <= DIFF_BITS'(p1.y) - DIFF_BITS'(p0.y);
         ux2_ff <= ux_in;
         uy2_ff <= uy_in;
         sx2_ff <= dx_ff[DIFF_BITS-1];
         sy2_ff <= dy_ff[DIFF_BITS-1];
         sqx_ff <= SQ_BITS'(ux_in) * SQ_BITS'(ux_in);
         sqy_ff <= SQ_BITS'(uy_in) * SQ_BITS'(uy_in);
         rad_ff <= sqx_ff + sqy_ff;
         ux3_ff <= ux2_ff;
         uy3_ff <= uy2_ff;
         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;
         for (int k = 0; k < ROOT_BITS; k++) begin
            if (k == 0) begin
               uxd_ff[k] <= ux3_ff;
               uyd_ff[k] <= uy3_ff;
               sgd_ff[k] <= {sx3_ff, sy3_ff};
            end else begin
               uxd_ff[k] <= uxd_ff[k-1];
               uyd_ff[k] <= uyd_ff[k-1];
               sgd_ff[k] <= sgd_ff[k-1];
            end
         end
      end
   end

   tpsc_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (len)
   );

   // Rounded quotient: (u * 2^14 + len/2) / len.
   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= (NUM_BITS'(uxd_ff[ROOT_BITS-1]) << UNIT_SHIFT) + NUM_BITS'(len >> 1);
         numy_ff <= (NUM_BITS'(uyd_ff[ROOT_BITS-1]) << UNIT_SHIFT) + NUM_BITS'(len >> 1);
         den_ff  <= len;
         flg4_ff <= {len == '0, sgd_ff[ROOT_BITS-1]};
         for (int k = 0; k < QUOT_BITS; k++) begin
            flgd_ff[k] <= (k == 0) ? flg4_ff : flgd_ff[k-1];
         end
         nrm_ff <= nrm_in;
      end
   end

   tpsc_div u_divx (
      .clock (clock),
      .en    (en),
      .num   (numx_ff),
      .den   (den_ff),
      .quot  (qx)
   );

   tpsc_div u_divy (
      .clock (clock),
      .en    (en),
      .num   (numy_ff),
      .den   (den_ff),
      .quot  (qy)
   );

   // The normal is (dy, -dx) / len; a degenerate edge gives the zero vector.
   always_comb begin
      if (flgd_ff[QUOT_BITS-1][2]) begin
         nrm_in.x = '0;
         nrm_in.y = '0;
      end else begin
         nrm_in.x = flgd_ff[QUOT_BITS-1][0] ? -NORM_BITS'(qy) : NORM_BITS'(qy);
         nrm_in.y = flgd_ff[QUOT_BITS-1][1] ? NORM_BITS'(qx) : -NORM_BITS'(qx);
      end
   end

   assign nrm = nrm_ff;
endmodule

### rtl/core/tpsc_sat.sv
module tpsc_sat import tpsc_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  normal_type nrm [AXES],
   input  pt_type     verts [VERTS],
   input  pt_type     pos_a,
   input  pt_type     pos_b,
   output rsp_type    res
);
   logic signed [PROD_BITS-1:0] px_ff [AXES][VERTS];
   logic signed [PROD_BITS-1:0] py_ff [AXES][VERTS];
   logic signed [DOT_BITS-1:0]  d_ff  [AXES][VERTS];
   logic signed [DOT_BITS-1:0]  la_ff [AXES], ha_ff [AXES], lb_ff [AXES], hb_ff [AXES];
   logic signed [DOT_BITS-1:0]  la_in [AXES], ha_in [AXES], lb_in [AXES], hb_in [AXES];
   logic signed [OV_BITS-1:0]   ov_ff [AXES];
   logic                        sep_ff [AXES];
   normal_type                  n1_ff [AXES], n2_ff [AXES], n3_ff [AXES], n4_ff [AXES];
   pt_type                      pa_ff [5], pb_ff [5];
   logic signed [OV_BITS-1:0]   gov_ff [2], gov_in [2];
   normal_type                  gn_ff [2], gn_in [2];
   logic                        int5_ff, int6_ff, int7_ff;
   logic                        from6_ff, from7_ff;
   normal_type                  n6_ff, n7_ff;
   logic signed [OV_BITS-1:0]   ov6_ff, ov7_ff;
   logic signed [DIR_BITS-1:0]  dx6_ff, dy6_ff;
   logic signed [FLIP_BITS-2:0] mx_ff, my_ff;
   logic signed [FLIP_BITS-1:0] dot;
   logic                        b_wins;
   logic [OV_BITS-UNIT_SHIFT-1:0] dq;

   // Projection extremes per axis; vertices 0..2 are triangle A, 3..5 triangle B.
   always_comb begin
      for (int j = 0; j < AXES; j++) begin
         la_in[j] = d_ff[j][0];
         ha_in[j] = d_ff[j][0];
         lb_in[j] = d_ff[j][3];
         hb_in[j] = d_ff[j][3];
         for (int v = 1; v < 3; v++) begin
            if (d_ff[j][v] < la_in[j]) la_in[j] = d_ff[j][v];
            if (d_ff[j][v] > ha_in[j]) ha_in[j] = d_ff[j][v];
            if (d_ff[j][v+3] < lb_in[j]) lb_in[j] = d_ff[j][v+3];
            if (d_ff[j][v+3] > hb_in[j]) hb_in[j] = d_ff[j][v+3];
         end
      end
   end

   // Least overlap within each triangle's three axes; strictly smaller wins.
   always_comb begin
      for (int g = 0; g < 2; g++) begin
         gov_in[g] = ov_ff[3*g];
         gn_in[g]  = n4_ff[3*g];
         for (int i = 1; i < 3; i++) begin
            if (ov_ff[3*g+i] < gov_in[g]) begin
               gov_in[g] = ov_ff[3*g+i];
               gn_in[g]  = n4_ff[3*g+i];
            end
         end
      end
   end

   assign b_wins = gov_ff[1] < gov_ff[0];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < AXES; j++) begin
            for (int v = 0; v < VERTS; v++) begin
               px_ff[j][v] <= verts[v].x * nrm[j].x;
               py_ff[j][v] <= verts[v].y * nrm[j].y;
               d_ff[j][v]  <= DOT_BITS'(px_ff[j][v]) + DOT_BITS'(py_ff[j][v]);
            end
            la_ff[j]  <= la_in[j];
            ha_ff[j]  <= ha_in[j];
            lb_ff[j]  <= lb_in[j];
            hb_ff[j]  <= hb_in[j];
            sep_ff[j] <= !(hb_ff[j] >= la_ff[j] && ha_ff[j] >= lb_ff[j]);
            ov_ff[j]  <= OV_BITS'((ha_ff[j] < hb_ff[j]) ? ha_ff[j] : hb_ff[j])
                       - OV_BITS'((la_ff[j] > lb_ff[j]) ? la_ff[j] : lb_ff[j]);
            n1_ff[j] <= nrm[j];
            n2_ff[j] <= n1_ff[j];
            n3_ff[j] <= n2_ff[j];
            n4_ff[j] <= n3_ff[j];
         end
         for (int s = 0; s < 5; s++) begin
            pa_ff[s] <= (s == 0) ? pos_a : pa_ff[s-1];
            pb_ff[s] <= (s == 0) ? pos_b : pb_ff[s-1];
         end
         gov_ff  <= gov_in;
         gn_ff   <= gn_in;
         int5_ff <= !(sep_ff[0] || sep_ff[1] || sep_ff[2] ||
                      sep_ff[3] || sep_ff[4] || sep_ff[5]);
         int6_ff  <= int5_ff;
         from6_ff <= !b_wins;
         n6_ff    <= b_wins ? gn_ff[1] : gn_ff[0];
         ov6_ff   <= b_wins ? gov_ff[1] : gov_ff[0];
         if (b_wins) begin
            dx6_ff <= DIR_BITS'(pa_ff[4].x) - DIR_BITS'(pb_ff[4].x);
            dy6_ff <= DIR_BITS'(pa_ff[4].y) - DIR_BITS'(pb_ff[4].y);
         end else begin
            dx6_ff <= DIR_BITS'(pb_ff[4].x) - DIR_BITS'(pa_ff[4].x);
            dy6_ff <= DIR_BITS'(pb_ff[4].y) - DIR_BITS'(pa_ff[4].y);
         end
         mx_ff     <= n6_ff.x * dx6_ff;
         my_ff     <= n6_ff.y * dy6_ff;
         int7_ff   <= int6_ff;
         from7_ff  <= from6_ff;
         n7_ff     <= n6_ff;
         ov7_ff    <= ov6_ff;
      end
   end

   assign dot = FLIP_BITS'(mx_ff) + FLIP_BITS'(my_ff);
   assign dq  = ov7_ff[OV_BITS-1:UNIT_SHIFT];

   always_comb begin
      res = '0;
      if (int7_ff) begin
         res.intersects    = 1'b1;
         res.normal_from_a = from7_ff ^ dot[FLIP_BITS-1];
         res.depth = (dq[OV_BITS-UNIT_SHIFT-1:DEPTH_BITS] != '0) ? '1
                                                                 : dq[DEPTH_BITS-1:0];
         res.axis_x = n7_ff.x;
         res.axis_y = n7_ff.y;
      end
   end
endmodule

### rtl/core/triangle_pair_sat_collision.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data  (two triangles, two positions)
// rsp_      out        rsp_valid/rsp_stall  rsp_data  (hit, side, depth, axis)
// One item enters per cycle while req_stall is low; each result is registered before it leaves.
// The result path runs through the edge normal pipeline: a 25-stage square root, then a
// 15-stage divider, followed by a 7-stage projection and selection pipeline.
// Reset is synchronous and clears only the valid bits.
// A stalled result freezes the whole pipeline, and req_stall follows it.
`include "assert_macros.svh"
module triangle_pair_sat_collision import tpsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int LAT = NORM_LAT + SAT_LAT;

   logic       adv;
   logic       vld_ff [LAT];
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, sat_res;
   req_type    dly_ff [NORM_LAT];
   req_type    late;
   pt_type     pts [VERTS];
   pt_type     late_pts [VERTS];
   normal_type nrm [AXES];

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   assign pts[0] = unpack_pt(req_data.tri_a_vert0);
   assign pts[1] = unpack_pt(req_data.tri_a_vert1);
   assign pts[2] = unpack_pt(req_data.tri_a_vert2);
   assign pts[3] = unpack_pt(req_data.tri_b_vert0);
   assign pts[4] = unpack_pt(req_data.tri_b_vert1);
   assign pts[5] = unpack_pt(req_data.tri_b_vert2);

   // Edge i runs from vertex i to the next vertex of the same triangle, wrapping from the last to the first.
   for (genvar j = 0; j < AXES; j++) begin : g_edge
      tpsc_normal u_normal (
         .clock (clock),
         .en    (adv),
         .p0    (pts[j]),
         .p1    (pts[(j / 3) * 3 + ((j % 3) + 1) % 3]),
         .nrm   (nrm[j])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NORM_LAT; k++) begin
            dly_ff[k] <= (k == 0) ? req_data : dly_ff[k-1];
         end
         rsp_data_ff <= sat_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= (k == 0) ? req_valid : vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   assign late        = dly_ff[NORM_LAT-1];
   assign late_pts[0] = unpack_pt(late.tri_a_vert0);
   assign late_pts[1] = unpack_pt(late.tri_a_vert1);
   assign late_pts[2] = unpack_pt(late.tri_a_vert2);
   assign late_pts[3] = unpack_pt(late.tri_b_vert0);
   assign late_pts[4] = unpack_pt(late.tri_b_vert1);
   assign late_pts[5] = unpack_pt(late.tri_b_vert2);

   tpsc_sat u_sat (
      .clock (clock),
      .en    (adv),
      .nrm   (nrm),
      .verts (late_pts),
      .pos_a (unpack_pt(late.body_a_pos)),
      .pos_b (unpack_pt(late.body_b_pos)),
      .res   (sat_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLKD(a_miss_is_zero, clock, reset,
      rsp_valid_ff && !rsp_data_ff.intersects |->
         rsp_data_ff.depth == '0 && rsp_data_ff.axis_x == '0 &&
         rsp_data_ff.axis_y == '0 && !rsp_data_ff.normal_from_a)
   `ASSERT_CLKD(a_axis_range, clock, reset,
      rsp_valid_ff |->
         rsp_data_ff.axis_x >= -NORM_BITS'(UNIT_ONE) &&
         rsp_data_ff.axis_x <= NORM_BITS'(UNIT_ONE) &&
         rsp_data_ff.axis_y >= -NORM_BITS'(UNIT_ONE) &&
         rsp_data_ff.axis_y <= NORM_BITS'(UNIT_ONE))
   `ASSERT_CLKD(a_accept_tracked, clock, reset,
      req_valid && !req_stall |=> vld_ff[0])
   `ASSERT_NEVER(a_result_dropped, clock, reset,
      !adv && vld_ff[LAT-1] && !$past(vld_ff[LAT-1]) && $past(adv) && !rsp_valid_ff)
endmodule
